FILE: src/id3pic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3pic_pkg
// shared types, constants and helpers for the id3v2 picture frame extractor
// ----------------------------------------------------------------------------
package id3pic_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_HDR,
    PH_FHDR,
    PH_SKIP,
    PH_ENC,
    PH_MIME,
    PH_PTYPE,
    PH_DESC,
    PH_IMAGE
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_IMAGE    = 2'd0,
    ST_NO_TAG   = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  localparam int unsigned TAG_SIZE_BITS_DEFAULT = 28;

  localparam logic [31:0] TARGET_ID_DEFAULT = 32'h4150_4943;  // "APIC"

  // "ID3" signature
  localparam logic [7:0] SIG_BYTE0 = 8'h49;
  localparam logic [7:0] SIG_BYTE1 = 8'h44;
  localparam logic [7:0] SIG_BYTE2 = 8'h33;

  localparam logic [7:0] SYNCHSAFE_VERSION = 8'd4;

  // byte positions inside the 10-byte tag header and frame header
  localparam logic [3:0] HDR_SIG0_IDX  = 4'd0;
  localparam logic [3:0] HDR_SIG1_IDX  = 4'd1;
  localparam logic [3:0] HDR_SIG2_IDX  = 4'd2;
  localparam logic [3:0] HDR_VER_IDX   = 4'd3;
  localparam logic [3:0] HDR_SIZE_IDX  = 4'd6;
  localparam logic [3:0] HDR_LAST_IDX  = 4'd9;
  localparam logic [3:0] FHDR_SIZE_IDX = 4'd4;
  localparam logic [3:0] FHDR_FLAG_IDX = 4'd8;
  localparam logic [3:0] FHDR_LAST_IDX = 4'd9;

  localparam int unsigned FRAME_HDR_BYTES = 10;

  // drop the top bit of each byte of a synchsafe word
  function automatic logic [27:0] unsync(input logic [31:0] v);
    unsync = {v[30:24], v[22:16], v[14:8], v[6:0]};
  endfunction

endpackage

FILE: src/id3v2_picture_frame_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_picture_frame_extractor
// walks an id3v2 tag in a byte stream and emits the image bytes of one frame
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                 marks
//  s_axis    in   tdata[7:0] data_byte                    tuser start_of_file,
//                                                         tlast end_of_file
//  m_axis    out  tdata[7:0] out_byte                     tuser out_status,
//                                                         tlast last_of_run
//  cfg       in   cfg_data[31:0] target_frame_id          cfg_we write strobe
//
//  one byte per cycle sustained while m_axis is not stalled; a byte goes from
//  the input register through the parse step, and any result it gives is held
//  in the output register, which drives m_axis_tvalid
//  the parse state is a handful of counters and shift registers updated once
//  per byte; the single step between input and output register sets the rate
//  synchronous active-high reset; no clearing pass, the block is ready at once
//  a stalled result holds the output register and the input register, so at
//  most one byte waits upstream of a blocked result
//
module id3v2_picture_frame_extractor #(
  parameter int unsigned TAG_SIZE_BITS = id3pic_pkg::TAG_SIZE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,      // target_frame_id
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] start_of_file
  input  logic        s_axis_tlast,  // end_of_file
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,  // [1:0] out_status
  output logic        m_axis_tlast   // last_of_run
);

  import id3pic_pkg::*;

  localparam logic [31:0] TAG_MAX = 32'((64'd1 << TAG_SIZE_BITS) - 64'd1);
  localparam logic [TAG_SIZE_BITS-1:0] FHDR_MIN = TAG_SIZE_BITS'(FRAME_HDR_BYTES);

  // target frame id register
  logic [31:0] target_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_id <= TARGET_ID_DEFAULT;
    end else if (cfg_we) begin
      target_id <= cfg_data;
    end
  end

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_sof;
  logic       in_eof;
  logic       advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_sof  <= s_axis_tuser;
      in_eof  <= s_axis_tlast;
    end
  end

  // parse state
  phase_t                   phase,           phase_next;
  logic [3:0]               field_index,     field_index_next;
  logic [TAG_SIZE_BITS-1:0] tag_length,      tag_length_next;
  logic [TAG_SIZE_BITS-1:0] tag_consumed,    tag_consumed_next;
  logic                     version4,        version4_next;
  logic [31:0]              frame_id_shift,  frame_id_shift_next;
  logic [31:0]              frame_size_shift, frame_size_shift_next;
  logic [TAG_SIZE_BITS-1:0] frame_remaining, frame_remaining_next;
  logic                     finished,        finished_next;

  // state as seen by this byte: a start of file clears the parse first
  phase_t                   ph;
  logic [3:0]               fidx;
  logic [TAG_SIZE_BITS-1:0] tlen;
  logic [TAG_SIZE_BITS-1:0] tcons;
  logic                     ver4;
  logic [31:0]              fid;
  logic [31:0]              fsz;
  logic [TAG_SIZE_BITS-1:0] frem;
  logic                     fin;

  assign ph    = in_sof ? PH_HDR : phase;
  assign fidx  = in_sof ? '0 : field_index;
  assign tlen  = in_sof ? '0 : tag_length;
  assign tcons = in_sof ? '0 : tag_consumed;
  assign ver4  = in_sof ? 1'b0 : version4;
  assign fid   = in_sof ? '0 : frame_id_shift;
  assign fsz   = in_sof ? '0 : frame_size_shift;
  assign frem  = in_sof ? '0 : frame_remaining;
  assign fin   = in_sof ? 1'b0 : finished;

  // step decisions shared with the result logic
  logic    fail;       // parse ends with an error status
  status_t fail_st;
  logic    emit_img;   // this byte is an image byte
  logic    img_last;   // and the last one of the frame

  // next-state logic
  always_comb begin
    logic [31:0]              hdr_size;
    logic [TAG_SIZE_BITS-1:0] tag_len_new;
    logic [TAG_SIZE_BITS-1:0] left;
    logic [TAG_SIZE_BITS-1:0] rem_dec;
    logic [31:0]              size;
    logic                     too_long;

    phase_next            = ph;
    field_index_next      = fidx;
    tag_length_next       = tlen;
    tag_consumed_next     = tcons;
    version4_next         = ver4;
    frame_id_shift_next   = fid;
    frame_size_shift_next = fsz;
    frame_remaining_next  = frem;
    fail                  = 1'b0;
    fail_st               = ST_NO_TAG;
    emit_img              = 1'b0;
    img_last              = 1'b0;

    hdr_size    = {fsz[24:0], in_byte[6:0]};
    tag_len_new = (hdr_size > TAG_MAX) ? TAG_MAX[TAG_SIZE_BITS-1:0]
                                       : hdr_size[TAG_SIZE_BITS-1:0];
    tag_consumed_next = tcons + {{(TAG_SIZE_BITS-1){1'b0}}, (tcons < tlen)};
    left        = tlen - tag_consumed_next;
    rem_dec     = frem - {{(TAG_SIZE_BITS-1){1'b0}}, (frem != '0)};
    size        = ver4 ? {4'd0, unsync(fsz)} : fsz;
    too_long    = size > 32'(left);

    if (!fin) begin
      unique case (ph)
        PH_HDR: begin
          tag_consumed_next = tcons;
          if ((fidx == HDR_SIG0_IDX && in_byte != SIG_BYTE0) ||
              (fidx == HDR_SIG1_IDX && in_byte != SIG_BYTE1) ||
              (fidx == HDR_SIG2_IDX && in_byte != SIG_BYTE2)) begin
            fail    = 1'b1;
            fail_st = ST_NO_TAG;
          end else begin
            if (fidx == HDR_VER_IDX) begin
              version4_next = (in_byte == SYNCHSAFE_VERSION);
            end
            if (fidx >= HDR_SIZE_IDX) begin
              frame_size_shift_next = hdr_size;
            end
            if (fidx >= HDR_LAST_IDX) begin
              tag_length_next   = tag_len_new;
              tag_consumed_next = '0;
              // an empty or tiny tag holds no frame header
              if (tag_len_new < FHDR_MIN) begin
                fail    = 1'b1;
                fail_st = ST_NO_FRAME;
              end else begin
                phase_next            = PH_FHDR;
                field_index_next      = '0;
                frame_id_shift_next   = '0;
                frame_size_shift_next = '0;
              end
            end else begin
              field_index_next = fidx + 4'd1;
            end
          end
        end
        PH_FHDR: begin
          if (fidx < FHDR_SIZE_IDX) begin
            frame_id_shift_next = {fid[23:0], in_byte};
          end else if (fidx < FHDR_FLAG_IDX) begin
            frame_size_shift_next = {fsz[23:0], in_byte};
          end
          if (fidx >= FHDR_LAST_IDX) begin
            if (fid == target_id) begin
              if (size == '0 || too_long) begin
                fail    = 1'b1;
                fail_st = ST_TRUNC;
              end else begin
                frame_remaining_next = size[TAG_SIZE_BITS-1:0];
                phase_next           = PH_ENC;
              end
            end else if (too_long) begin
              fail    = 1'b1;
              fail_st = ST_NO_FRAME;
            end else if (size == '0) begin
              if (left < FHDR_MIN) begin
                fail    = 1'b1;
                fail_st = ST_NO_FRAME;
              end else begin
                field_index_next      = '0;
                frame_id_shift_next   = '0;
                frame_size_shift_next = '0;
              end
            end else begin
              frame_remaining_next = size[TAG_SIZE_BITS-1:0];
              phase_next           = PH_SKIP;
            end
          end else begin
            field_index_next = fidx + 4'd1;
          end
        end
        PH_SKIP: begin
          frame_remaining_next = rem_dec;
          if (rem_dec == '0) begin
            if (left < FHDR_MIN) begin
              fail    = 1'b1;
              fail_st = ST_NO_FRAME;
            end else begin
              phase_next            = PH_FHDR;
              field_index_next      = '0;
              frame_id_shift_next   = '0;
              frame_size_shift_next = '0;
            end
          end
        end
        PH_IMAGE: begin
          frame_remaining_next = rem_dec;
          emit_img             = 1'b1;
          img_last             = (rem_dec == '0);
        end
        PH_ENC, PH_MIME, PH_PTYPE, PH_DESC: begin
          frame_remaining_next = rem_dec;
          case (ph)
            PH_ENC:   phase_next = PH_MIME;
            PH_MIME:  phase_next = (in_byte == 8'd0) ? PH_PTYPE : PH_MIME;
            PH_PTYPE: phase_next = PH_DESC;
            default:  phase_next = (in_byte == 8'd0) ? PH_IMAGE : PH_DESC;
          endcase
          // frame ran out before any image byte
          if (rem_dec == '0) begin
            fail    = 1'b1;
            fail_st = ST_TRUNC;
          end
        end
      endcase
    end

    finished_next = fin || fail || img_last || in_eof;
  end

  // result logic
  logic       res_valid;
  logic [7:0] res_byte;
  status_t    res_status;
  logic       res_last;

  always_comb begin
    res_valid  = !fin && (fail || emit_img || in_eof);
    res_byte   = emit_img ? in_byte : 8'd0;
    res_last   = fail || img_last || in_eof;
    res_status = ST_IMAGE;
    if (fail) begin
      res_status = fail_st;
    end else if (emit_img) begin
      // file cut short inside the image
      res_status = (in_eof && !img_last) ? ST_TRUNC : ST_IMAGE;
    end else begin
      unique case (phase_next)
        PH_HDR:           res_status = ST_NO_TAG;
        PH_FHDR, PH_SKIP: res_status = ST_NO_FRAME;
        default:          res_status = ST_TRUNC;
      endcase
    end
  end

  // state registers, stepped once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR;
      field_index      <= '0;
      tag_length       <= '0;
      tag_consumed     <= '0;
      version4         <= 1'b0;
      frame_id_shift   <= '0;
      frame_size_shift <= '0;
      frame_remaining  <= '0;
      finished         <= 1'b0;
    end else if (advance) begin
      phase            <= phase_next;
      field_index      <= field_index_next;
      tag_length       <= tag_length_next;
      tag_consumed     <= tag_consumed_next;
      version4         <= version4_next;
      frame_id_shift   <= frame_id_shift_next;
      frame_size_shift <= frame_size_shift_next;
      frame_remaining  <= frame_remaining_next;
      finished         <= finished_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res_valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_axis_tdata <= res_byte;
      m_axis_tuser <= res_status;
      m_axis_tlast <= res_last;
    end
  end

endmodule
